// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the ranging alarm RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked while reset is low.
`define URA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define URA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`else

`define URA_ASSERT(lbl, clk, rst, prop, msg)
`define URA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/ura_pkg.sv =====
// ----------------------------------------------------------------------------
// ura_pkg
// Types, constants and lookup functions shared by the ranging alarm modules.
// ----------------------------------------------------------------------------
package ura_pkg;

   localparam int DIST_BITS = 14;
   localparam logic [DIST_BITS-1:0] DIST_MAX = 14'd9999;

   // 680/1000 reduced
   localparam int SCALE_NUM = 17;
   localparam int SCALE_DEN = 25;

   // wide enough for two milliseconds of ticks (2 * 1023)
   localparam int PHASE_TICK_BITS = 11;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TRIG_LOW    = 3'd0,
      CSR_TRIG_HIGH   = 3'd1,
      CSR_MS_TICKS    = 3'd2,
      CSR_NEAR_MM     = 3'd3,
      CSR_MID_MM      = 3'd4,
      CSR_FAR_MM      = 3'd5,
      CSR_DIGIT_TICKS = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ZONE_NEAR = 2'd0,
      ZONE_MID  = 2'd1,
      ZONE_FAR  = 2'd2,
      ZONE_NONE = 2'd3
   } zone_type;

   // four decimal digits, [0] = ones
   typedef logic [3:0][3:0] bcd_type;

   typedef struct packed {
      logic [7:0]           trig_low_ticks;
      logic [7:0]           trig_high_ticks;
      logic [9:0]           ms_ticks;
      logic [DIST_BITS-1:0] near_mm;
      logic [DIST_BITS-1:0] mid_mm;
      logic [DIST_BITS-1:0] far_mm;
      logic [15:0]          digit_ticks;
   } cfg_type;

   // ranging status for one item: trig/buzz before the update, rest after
   typedef struct packed {
      logic                 trig;
      logic                 buzz;
      logic [DIST_BITS-1:0] dist_mm;
      logic                 pulse;
      zone_type             zone;
   } rng_status_type;

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0:    pat = 8'h3f;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5b;
         4'd3:    pat = 8'h4f;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6d;
         4'd6:    pat = 8'h7c;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7f;
         4'd9:    pat = 8'h67;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   function automatic logic [7:0] beep_cycles(input zone_type zone);
      logic [7:0] n;
      unique case (zone)
         ZONE_NEAR: n = 8'd5;
         ZONE_MID:  n = 8'd50;
         ZONE_FAR:  n = 8'd250;
         default:   n = 8'd0;
      endcase
      return n;
   endfunction

   // silence in 2 ms units
   function automatic logic [7:0] silence_units(input zone_type zone);
      logic [7:0] n;
      unique case (zone)
         ZONE_MID: n = 8'd50;
         ZONE_FAR: n = 8'd150;
         default:  n = 8'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== design/ura_display.sv =====
// ----------------------------------------------------------------------------
// ura_display
// Four-digit seven-segment scanner with uniform dwell per digit.
// ----------------------------------------------------------------------------
module ura_display (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [15:0]    digit_ticks,
   input  ura_pkg::bcd_type digits,
   output logic [7:0]     segment_bits,
   output logic [3:0]     digit_select
);
   import ura_pkg::*;

   logic [1:0]  scan_index_ff, scan_index_in;
   logic [15:0] scan_ticks_ff, scan_ticks_in;
   logic [16:0] ticks_inc;
   logic [15:0] dwell;
   logic        wrap;

   assign dwell     = (digit_ticks == 16'd0) ? 16'd1 : digit_ticks;
   assign ticks_inc = {1'b0, scan_ticks_ff} + 17'd1;
   assign wrap      = (ticks_inc >= {1'b0, dwell});

   always_comb begin
      scan_index_in = scan_index_ff;
      scan_ticks_in = scan_ticks_ff;
      if (step) begin
         if (wrap) begin
            scan_ticks_in = 16'd0;
            scan_index_in = scan_index_ff + 2'd1;
         end else begin
            scan_ticks_in = ticks_inc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_index_ff <= 2'd0;
         scan_ticks_ff <= 16'd0;
      end else begin
         scan_index_ff <= scan_index_in;
         scan_ticks_ff <= scan_ticks_in;
      end
   end

   // decimal point sits on the tens digit (reads as centimeters, one decimal)
   assign segment_bits = seg_pattern(digits[scan_index_ff]) |
                         ((scan_index_ff == 2'd1) ? 8'h80 : 8'h00);
   assign digit_select = 4'b0001 << scan_index_ff;

endmodule

// ===== design/ura_ranging.sv =====
// ----------------------------------------------------------------------------
// ura_ranging
// Trigger / echo sequencer, running distance and zone, buzzer pattern.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ura_ranging #(
   parameter int ECHO_COUNT_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    echo_level,
   input  ura_pkg::cfg_type        cfg,
   output ura_pkg::rng_status_type status,
   output ura_pkg::bcd_type        dist_digits
);
   import ura_pkg::*;

   typedef enum logic [2:0] {
      PH_TRIG_LOW  = 3'd0,
      PH_TRIG_HIGH = 3'd1,
      PH_WAIT_ECHO = 3'd2,
      PH_COUNT     = 3'd3,
      PH_BEEP      = 3'd4,
      PH_SILENCE   = 3'd5
   } phase_type;

   localparam logic [ECHO_COUNT_BITS-1:0] COUNT_MAX = {ECHO_COUNT_BITS{1'b1}};
   localparam logic [4:0] NUM = 5'(SCALE_NUM);
   localparam logic [5:0] DEN = 6'(SCALE_DEN);

   phase_type                  phase_ff, phase_in;
   logic [PHASE_TICK_BITS-1:0] pt_ff, pt_in;
   logic [ECHO_COUNT_BITS-1:0] echo_ticks_ff, echo_ticks_in;
   logic [DIST_BITS-1:0]       run_dist_ff, run_dist_in;
   bcd_type                    run_bcd_ff, run_bcd_in;
   logic [4:0]                 run_rem_ff, run_rem_in;
   logic [DIST_BITS-1:0]       meas_ff, meas_in;
   bcd_type                    meas_bcd_ff, meas_bcd_in;
   zone_type                   zone_ff, zone_in;
   logic [7:0]                 beep_left_ff, beep_left_in;
   logic                       buzz_ff, buzz_in;
   logic                       pulse;

   function automatic bcd_type bcd_inc(input bcd_type v);
      bcd_type r;
      logic    carry;
      r     = v;
      carry = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (carry) begin
            if (v[i] == 4'd9) begin
               r[i] = 4'd0;
            end else begin
               r[i]  = v[i] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return r;
   endfunction

   always_comb begin
      logic [PHASE_TICK_BITS:0] pt_inc;
      logic [PHASE_TICK_BITS:0] ms1;
      logic [PHASE_TICK_BITS:0] two_ms;
      logic [PHASE_TICK_BITS:0] low1;
      logic [PHASE_TICK_BITS:0] high1;
      logic [7:0]               bl_dec;
      logic [5:0]               rem_sum;
      zone_type                 zn;

      pt_inc  = {1'b0, pt_ff} + 12'd1;
      ms1     = {2'b00, ((cfg.ms_ticks == 10'd0) ? 10'd1 : cfg.ms_ticks)};
      two_ms  = {ms1[PHASE_TICK_BITS-1:0], 1'b0};
      low1    = {4'd0, ((cfg.trig_low_ticks == 8'd0) ? 8'd1 : cfg.trig_low_ticks)};
      high1   = {4'd0, ((cfg.trig_high_ticks == 8'd0) ? 8'd1 : cfg.trig_high_ticks)};
      bl_dec  = (beep_left_ff != 8'd0) ? beep_left_ff - 8'd1 : 8'd0;
      rem_sum = {1'b0, run_rem_ff} + {1'b0, NUM};
      zn      = ZONE_NONE;

      phase_in      = phase_ff;
      pt_in         = pt_ff;
      echo_ticks_in = echo_ticks_ff;
      run_dist_in   = run_dist_ff;
      run_bcd_in    = run_bcd_ff;
      run_rem_in    = run_rem_ff;
      meas_in       = meas_ff;
      meas_bcd_in   = meas_bcd_ff;
      zone_in       = zone_ff;
      beep_left_in  = beep_left_ff;
      buzz_in       = buzz_ff;
      pulse         = 1'b0;

      if (step) begin
         unique case (phase_ff)
            PH_TRIG_LOW: begin
               if (pt_inc >= low1) begin
                  phase_in = PH_TRIG_HIGH;
                  pt_in    = '0;
               end else begin
                  pt_in = pt_inc[PHASE_TICK_BITS-1:0];
               end
            end
            PH_TRIG_HIGH: begin
               if (pt_inc >= high1) begin
                  phase_in = PH_WAIT_ECHO;
                  pt_in    = '0;
               end else begin
                  pt_in = pt_inc[PHASE_TICK_BITS-1:0];
               end
            end
            PH_WAIT_ECHO: begin
               if (echo_level) begin
                  phase_in      = PH_COUNT;
                  echo_ticks_in = {{(ECHO_COUNT_BITS-1){1'b0}}, 1'b1};
                  // 17*1 / 25: quotient 0, remainder 17
                  run_dist_in   = '0;
                  run_bcd_in    = '0;
                  run_rem_in    = NUM;
               end
            end
            PH_COUNT: begin
               if (echo_level) begin
                  if (echo_ticks_ff != COUNT_MAX) begin
                     echo_ticks_in = echo_ticks_ff + 1'b1;
                     // running floor(17*count/25); quotient steps by at most one
                     if (rem_sum >= DEN) begin
                        run_rem_in = 5'(rem_sum - DEN);
                        if (run_dist_ff != DIST_MAX) begin
                           run_dist_in = run_dist_ff + 1'b1;
                           run_bcd_in  = bcd_inc(run_bcd_ff);
                        end
                     end else begin
                        run_rem_in = rem_sum[4:0];
                     end
                  end
               end else begin
                  meas_in     = run_dist_ff;
                  meas_bcd_in = run_bcd_ff;
                  pulse       = 1'b1;
                  priority if (run_dist_ff < cfg.near_mm) zn = ZONE_NEAR;
                  else if (run_dist_ff < cfg.mid_mm)      zn = ZONE_MID;
                  else if (run_dist_ff < cfg.far_mm)      zn = ZONE_FAR;
                  else                                    zn = ZONE_NONE;
                  zone_in = zn;
                  pt_in   = '0;
                  if (zn != ZONE_NONE) begin
                     phase_in     = PH_BEEP;
                     beep_left_in = beep_cycles(zn);
                     buzz_in      = 1'b1;
                  end else begin
                     phase_in = PH_TRIG_LOW;
                     buzz_in  = 1'b0;
                  end
               end
            end
            PH_BEEP: begin
               if (pt_inc >= two_ms) begin
                  pt_in        = '0;
                  beep_left_in = bl_dec;
                  if (bl_dec == 8'd0) begin
                     buzz_in = 1'b0;
                     if (silence_units(zone_ff) == 8'd0) begin
                        phase_in = PH_TRIG_LOW;
                     end else begin
                        phase_in     = PH_SILENCE;
                        beep_left_in = silence_units(zone_ff);
                     end
                  end else begin
                     buzz_in = 1'b1;
                  end
               end else begin
                  pt_in = pt_inc[PHASE_TICK_BITS-1:0];
                  if (pt_inc >= ms1) buzz_in = 1'b0;
               end
            end
            PH_SILENCE: begin
               buzz_in = 1'b0;
               if (pt_inc >= two_ms) begin
                  pt_in        = '0;
                  beep_left_in = bl_dec;
                  if (bl_dec == 8'd0) phase_in = PH_TRIG_LOW;
               end else begin
                  pt_in = pt_inc[PHASE_TICK_BITS-1:0];
               end
            end
            default: begin
               phase_in = PH_TRIG_LOW;
               pt_in    = '0;
               buzz_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TRIG_LOW;
         pt_ff         <= '0;
         echo_ticks_ff <= '0;
         run_dist_ff   <= '0;
         run_bcd_ff    <= '0;
         run_rem_ff    <= '0;
         meas_ff       <= '0;
         meas_bcd_ff   <= '0;
         zone_ff       <= ZONE_NONE;
         beep_left_ff  <= '0;
         buzz_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pt_ff         <= pt_in;
         echo_ticks_ff <= echo_ticks_in;
         run_dist_ff   <= run_dist_in;
         run_bcd_ff    <= run_bcd_in;
         run_rem_ff    <= run_rem_in;
         meas_ff       <= meas_in;
         meas_bcd_ff   <= meas_bcd_in;
         zone_ff       <= zone_in;
         beep_left_ff  <= beep_left_in;
         buzz_ff       <= buzz_in;
      end
   end

   assign status.trig    = (phase_ff == PH_TRIG_HIGH);
   assign status.buzz    = buzz_ff;
   assign status.dist_mm = meas_in;
   assign status.pulse   = pulse;
   assign status.zone    = zone_in;
   assign dist_digits    = meas_bcd_ff;

   `URA_ASSERT(a_rem_below_den, clock, reset,
      (phase_ff == PH_COUNT) |-> ({1'b0, run_rem_ff} < DEN), "remainder out of range")
   `URA_ASSERT(a_alarm_has_zone, clock, reset,
      ((phase_ff == PH_BEEP) || (phase_ff == PH_SILENCE)) |-> (zone_ff != ZONE_NONE),
      "beep or silence without an alert zone")
   `URA_ASSERT(a_beep_count_live, clock, reset,
      ((phase_ff == PH_BEEP) || (phase_ff == PH_SILENCE)) |-> (beep_left_ff != 8'd0),
      "beep or silence with no cycles left")
   `URA_ASSERT(a_dist_saturated, clock, reset,
      (meas_ff <= DIST_MAX) && (run_dist_ff <= DIST_MAX), "distance above 9999")

endmodule

// ===== design/ultrasonic_ranging_alarm_unit.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_ranging_alarm_unit
// Ultrasonic ranging controller with zoned buzzer alarm and 4-digit display.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (req_*): one item per 4 us tick carrying the sampled echo
//    pin. Output channel (rsp_*): exactly one result item per input item.
//  - csr_* is a write-only register port; write only while no item is in
//    flight. Indexes: trig low/high ticks, ms ticks, near/mid/far mm,
//    digit dwell ticks.
//  - Latency: a result appears on rsp_valid the cycle after its item is
//    accepted. Throughput: one item per cycle while rsp_ready is high; all
//    per-item work is one level of logic from state to result registers.
//  - trig_out, buzzer_out, segment_bits and digit_select reflect state before
//    the item; distance_mm, new_measure and alert_zone reflect it after.
//  - Distance is built up incrementally while echo is high, so latching it
//    costs no divider.
//  - Reset (synchronous): sequencer restarts at trigger low, distance 0,
//    zone none, buzzer off, scan at digit 0, registers to defaults.
//  - When rsp_ready is low the result is held and req_ready drops, so no
//    further item is taken until the pending result leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_ranging_alarm_unit #(
   parameter int ECHO_COUNT_BITS = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_echo_level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_trig_out,
   output logic                               rsp_buzzer_out,
   output logic [7:0]                         rsp_segment_bits,
   output logic [3:0]                         rsp_digit_select,
   output logic [ura_pkg::DIST_BITS-1:0]      rsp_distance_mm,
   output logic                               rsp_new_measure,
   output logic [1:0]                         rsp_alert_zone,
   input  logic                               csr_we,
   input  logic [ura_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ura_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import ura_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   rng_status_type rng_status;
   bcd_type        dist_digits;
   logic [7:0]     seg;
   logic [3:0]     dsel;
   logic           step;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 trig_ff, buzz_ff, pulse_ff;
   logic [7:0]           seg_ff;
   logic [3:0]           dsel_ff;
   logic [DIST_BITS-1:0] dist_ff;
   zone_type             zone_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TRIG_LOW:    cfg_in.trig_low_ticks  = csr_wdata[7:0];
            CSR_TRIG_HIGH:   cfg_in.trig_high_ticks = csr_wdata[7:0];
            CSR_MS_TICKS:    cfg_in.ms_ticks        = csr_wdata[9:0];
            CSR_NEAR_MM:     cfg_in.near_mm         = csr_wdata[DIST_BITS-1:0];
            CSR_MID_MM:      cfg_in.mid_mm          = csr_wdata[DIST_BITS-1:0];
            CSR_FAR_MM:      cfg_in.far_mm          = csr_wdata[DIST_BITS-1:0];
            CSR_DIGIT_TICKS: cfg_in.digit_ticks     = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trig_low_ticks  <= 8'd3;
         cfg_ff.trig_high_ticks <= 8'd3;
         cfg_ff.ms_ticks        <= 10'd250;
         cfg_ff.near_mm         <= 14'd300;
         cfg_ff.mid_mm          <= 14'd600;
         cfg_ff.far_mm          <= 14'd1000;
         cfg_ff.digit_ticks     <= 16'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ura_ranging #(
      .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
   ) u_ranging (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .echo_level  (req_echo_level),
      .cfg         (cfg_ff),
      .status      (rng_status),
      .dist_digits (dist_digits)
   );

   ura_display u_display (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .digit_ticks  (cfg_ff.digit_ticks),
      .digits       (dist_digits),
      .segment_bits (seg),
      .digit_select (dsel)
   );

   // result register
   assign rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         trig_ff  <= rng_status.trig;
         buzz_ff  <= rng_status.buzz;
         seg_ff   <= seg;
         dsel_ff  <= dsel;
         dist_ff  <= rng_status.dist_mm;
         pulse_ff <= rng_status.pulse;
         zone_ff  <= rng_status.zone;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_trig_out     = trig_ff;
   assign rsp_buzzer_out   = buzz_ff;
   assign rsp_segment_bits = seg_ff;
   assign rsp_digit_select = dsel_ff;
   assign rsp_distance_mm  = dist_ff;
   assign rsp_new_measure  = pulse_ff;
   assign rsp_alert_zone   = zone_ff;

   `URA_ASSERT(a_pulse_reaches_rsp, clock, reset,
      (step && rng_status.pulse) |=> (rsp_valid && rsp_new_measure),
      "measurement pulse lost")
   `URA_ASSERT(a_digit_onehot, clock, reset,
      rsp_valid |-> $onehot(rsp_digit_select), "digit select not one-hot")
   `URA_ASSERT(a_rsp_dist_range, clock, reset,
      rsp_valid |-> (rsp_distance_mm <= DIST_MAX), "result distance above 9999")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ultrasonic ranging alarm unit. Feeds echo pin
// samples, predicts trigger, buzzer, display scan and distance per item, and
// checks every result item under a range of register settings.
// ----------------------------------------------------------------------------
module tb;
   import ura_pkg::*;

   localparam int ECHO_BITS = 14;
   localparam logic [ECHO_BITS-1:0] COUNT_MAX = '1;
   localparam int unsigned RUN_LIMIT = 50_000;
   // seven-segment glyphs for 9 down to 0
   localparam logic [79:0] GLYPHS = {8'h67, 8'h7f, 8'h07, 8'h7c, 8'h6d,
                                     8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

   typedef enum logic [2:0] {
      PH_TRIG_LOW  = 3'd0,
      PH_TRIG_HIGH = 3'd1,
      PH_WAIT_ECHO = 3'd2,
      PH_COUNT     = 3'd3,
      PH_BEEP      = 3'd4,
      PH_SILENCE   = 3'd5
   } seq_phase_type;

   typedef struct {
      seq_phase_type        phase;
      logic [16:0]          phase_ticks;
      logic [ECHO_BITS-1:0] echo_ticks;
      logic [DIST_BITS-1:0] distance;
      zone_type             zone;
      logic [7:0]           cycles_left;
      logic                 buzz;
      logic [1:0]           scan_idx;
      logic [15:0]          scan_ticks;
   } ranger_state_type;

   typedef struct {
      logic                 trig;
      logic                 buzz;
      logic [7:0]           seg;
      logic [3:0]           digit;
      logic [DIST_BITS-1:0] distance;
      logic                 pulse;
      zone_type             zone;
   } reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_echo_level = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_trig_out;
   logic                      rsp_buzzer_out;
   logic [7:0]                rsp_segment_bits;
   logic [3:0]                rsp_digit_select;
   logic [DIST_BITS-1:0]      rsp_distance_mm;
   logic                      rsp_new_measure;
   logic [1:0]                rsp_alert_zone;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   cfg_type          cfg_now;
   ranger_state_type dut_view;    // advanced on accepted items
   ranger_state_type plan_view;   // advanced as items are queued
   logic             echo_samples[$];
   reading_type      expected_readings[$];
   int unsigned      cycle_count = 0;
   int unsigned      stall_left = 0;
   bit               failed = 1'b0;
   logic             calm;

   ultrasonic_ranging_alarm_unit #(
      .ECHO_COUNT_BITS(ECHO_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_echo_level   (req_echo_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_trig_out     (rsp_trig_out),
      .rsp_buzzer_out   (rsp_buzzer_out),
      .rsp_segment_bits (rsp_segment_bits),
      .rsp_digit_select (rsp_digit_select),
      .rsp_distance_mm  (rsp_distance_mm),
      .rsp_new_measure  (rsp_new_measure),
      .rsp_alert_zone   (rsp_alert_zone),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // no random idling on either side inside this window
   assign calm = (cycle_count >= 600) && (cycle_count < 800);

   function automatic ranger_state_type fresh_state();
      ranger_state_type s;
      s.phase       = PH_TRIG_LOW;
      s.phase_ticks = '0;
      s.echo_ticks  = '0;
      s.distance    = '0;
      s.zone        = ZONE_NONE;
      s.cycles_left = '0;
      s.buzz        = 1'b0;
      s.scan_idx    = '0;
      s.scan_ticks  = '0;
      return s;
   endfunction

   function automatic void restart_trigger(inout ranger_state_type s);
      s.phase       = PH_TRIG_LOW;
      s.phase_ticks = '0;
      s.buzz        = 1'b0;
   endfunction

   function automatic void advance_ranger(inout ranger_state_type s, input cfg_type c,
                                          input logic echo, output reading_type r);
      logic [16:0] ms_len, two_ms, low_len, high_len;
      logic [15:0] dwell;
      logic [7:0]  units;
      int unsigned d, digit_val, mm;
      ms_len   = (c.ms_ticks == 0) ? 17'd1 : 17'(c.ms_ticks);
      two_ms   = ms_len << 1;
      low_len  = (c.trig_low_ticks == 0) ? 17'd1 : 17'(c.trig_low_ticks);
      high_len = (c.trig_high_ticks == 0) ? 17'd1 : 17'(c.trig_high_ticks);
      dwell    = (c.digit_ticks == 0) ? 16'd1 : c.digit_ticks;

      r.trig = (s.phase == PH_TRIG_HIGH);
      r.buzz = s.buzz;
      d = 32'(s.distance);
      case (s.scan_idx)
         2'd0: digit_val = d % 10;
         2'd1: digit_val = (d / 10) % 10;
         2'd2: digit_val = (d / 100) % 10;
         default: digit_val = (d / 1000) % 10;
      endcase
      r.seg   = GLYPHS[digit_val*8 +: 8] | ((s.scan_idx == 2'd1) ? 8'h80 : 8'h00);
      r.digit = 4'b0001 << s.scan_idx;
      s.scan_ticks = s.scan_ticks + 16'd1;
      if (s.scan_ticks >= dwell || s.scan_ticks == 0) begin
         s.scan_ticks = '0;
         s.scan_idx   = s.scan_idx + 2'd1;
      end

      r.pulse = 1'b0;
      case (s.phase)
         PH_TRIG_LOW: begin
            s.phase_ticks = s.phase_ticks + 17'd1;
            if (s.phase_ticks >= low_len) begin
               s.phase       = PH_TRIG_HIGH;
               s.phase_ticks = '0;
            end
         end
         PH_TRIG_HIGH: begin
            s.phase_ticks = s.phase_ticks + 17'd1;
            if (s.phase_ticks >= high_len) begin
               s.phase       = PH_WAIT_ECHO;
               s.phase_ticks = '0;
            end
         end
         PH_WAIT_ECHO: begin
            if (echo) begin
               s.echo_ticks = ECHO_BITS'(1);
               s.phase      = PH_COUNT;
            end
         end
         PH_COUNT: begin
            if (echo) begin
               if (s.echo_ticks != COUNT_MAX) s.echo_ticks = s.echo_ticks + 1'b1;
            end else begin
               mm = 32'(s.echo_ticks);
               mm = mm * 680 / 1000;
               s.distance = (mm > 9999) ? 14'd9999 : DIST_BITS'(mm);
               r.pulse    = 1'b1;
               if (s.distance < c.near_mm) s.zone = ZONE_NEAR;
               else if (s.distance < c.mid_mm) s.zone = ZONE_MID;
               else if (s.distance < c.far_mm) s.zone = ZONE_FAR;
               else s.zone = ZONE_NONE;
               if (s.zone != ZONE_NONE) begin
                  s.phase       = PH_BEEP;
                  s.phase_ticks = '0;
                  s.buzz        = 1'b1;
                  case (s.zone)
                     ZONE_NEAR: s.cycles_left = 8'd5;
                     ZONE_MID:  s.cycles_left = 8'd50;
                     default:   s.cycles_left = 8'd250;
                  endcase
               end else begin
                  restart_trigger(s);
               end
            end
         end
         PH_BEEP: begin
            s.phase_ticks = s.phase_ticks + 17'd1;
            if (s.phase_ticks >= two_ms) begin
               s.phase_ticks = '0;
               if (s.cycles_left != 0) s.cycles_left = s.cycles_left - 8'd1;
               if (s.cycles_left == 0) begin
                  // silence counted in 2 ms units
                  case (s.zone)
                     ZONE_MID: units = 8'd50;
                     ZONE_FAR: units = 8'd150;
                     default:  units = 8'd0;
                  endcase
                  if (units == 0) begin
                     restart_trigger(s);
                  end else begin
                     s.phase       = PH_SILENCE;
                     s.cycles_left = units;
                     s.buzz        = 1'b0;
                  end
               end else begin
                  s.buzz = 1'b1;
               end
            end else if (s.phase_ticks >= ms_len) begin
               s.buzz = 1'b0;
            end
         end
         PH_SILENCE: begin
            s.buzz = 1'b0;
            s.phase_ticks = s.phase_ticks + 17'd1;
            if (s.phase_ticks >= two_ms) begin
               s.phase_ticks = '0;
               if (s.cycles_left != 0) s.cycles_left = s.cycles_left - 8'd1;
               if (s.cycles_left == 0) restart_trigger(s);
            end
         end
         default: restart_trigger(s);
      endcase
      r.distance = s.distance;
      r.zone     = s.zone;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failed = 1'b1;
      end
   endfunction

   // ---- stimulus planning: the plan view tracks the block through queued items
   function automatic void queue_tick(input logic echo);
      reading_type unused;
      advance_ranger(plan_view, cfg_now, echo, unused);
      echo_samples.push_back(echo);
   endfunction

   function automatic void queue_noise(input int unsigned n);
      repeat (n) queue_tick($urandom_range(0, 3) == 0);
   endfunction

   // lead low samples, then echo high for span samples, then the falling edge
   function automatic void queue_measure(input int unsigned lead, input int unsigned span);
      while (plan_view.phase != PH_WAIT_ECHO) queue_tick($urandom_range(0, 3) == 0);
      repeat (lead) queue_tick(1'b0);
      repeat (span) queue_tick(1'b1);
      queue_tick(1'b0);
   endfunction

   // echo lengths clustered around the near threshold
   function automatic int unsigned pick_span();
      int unsigned thr, base;
      thr = 32'(cfg_now.near_mm);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 40);
      base = (thr * 25 + 16) / 17 + $urandom_range(0, 2);
      return (base > 1) ? base - 1 : 1;
   endfunction

   task automatic write_reg(input csr_index_type idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      case (idx)
         CSR_TRIG_LOW:    cfg_now.trig_low_ticks  = val[7:0];
         CSR_TRIG_HIGH:   cfg_now.trig_high_ticks = val[7:0];
         CSR_MS_TICKS:    cfg_now.ms_ticks        = val[9:0];
         CSR_NEAR_MM:     cfg_now.near_mm         = val[13:0];
         CSR_MID_MM:      cfg_now.mid_mm          = val[13:0];
         CSR_FAR_MM:      cfg_now.far_mm          = val[13:0];
         CSR_DIGIT_TICKS: cfg_now.digit_ticks     = val[15:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input int unsigned trig_lo, input int unsigned trig_hi,
                               input int unsigned ms, input int unsigned near,
                               input int unsigned mid, input int unsigned far,
                               input int unsigned dwell);
      write_reg(CSR_TRIG_LOW, trig_lo);
      write_reg(CSR_TRIG_HIGH, trig_hi);
      write_reg(CSR_MS_TICKS, ms);
      write_reg(CSR_NEAR_MM, near);
      write_reg(CSR_MID_MM, mid);
      write_reg(CSR_FAR_MM, far);
      write_reg(CSR_DIGIT_TICKS, dwell);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (echo_samples.size() != 0 || req_valid || expected_readings.size() != 0);
   endtask

   initial begin : stimulus
      int unsigned thr_mm;
      cfg_now   = '{8'd3, 8'd3, 10'd250, 14'd300, 14'd600, 14'd1000, 16'd500};
      dut_view  = fresh_state();
      plan_view = fresh_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers: a near echo, registers change inside its beep
      queue_measure(2, 100);
      queue_noise(12);
      drain();

      program_regs(1, 1, 1, 5, 10, 20, 1);
      queue_measure(0, 1);
      queue_measure(3, 8);     // mid zone: full beep and silence
      queue_measure(1, 7);
      drain();

      // zero tick counts act as one; all thresholds zero gives no alert
      program_regs(0, 0, 0, 0, 0, 0, 0);
      queue_measure(0, 3);
      queue_measure(1, 40);
      drain();

      // thresholds out of order
      program_regs(2, 3, 1, 12, 40, 6, 3);
      queue_measure(0, 10);
      queue_measure(0, 70);
      drain();

      thr_mm = $urandom_range(5, 30);
      program_regs($urandom_range(1, 3), $urandom_range(1, 3), 1,
                   thr_mm, thr_mm, thr_mm, $urandom_range(1, 6));
      repeat (3) begin
         queue_measure(($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0,
                       pick_span());
      end
      queue_noise($urandom_range(0, 10));
      drain();

      // far zone, then the widest register values while its beep runs
      program_regs(1, 1, 1, 2, 4, 30, 2);
      queue_measure(0, 10);
      queue_noise(30);
      drain();

      program_regs(255, 255, 1023, 9999, 9999, 9999, 65535);
      queue_noise(40);
      drain();

      repeat (8) @(posedge clock);
      if (expected_readings.size() != 0) begin
         $error("%0d result items never arrived", expected_readings.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("PASS ultrasonic_ranging_alarm_unit");
      end else begin
         $display("FAIL ultrasonic_ranging_alarm_unit");
      end
      $finish;
   end

   // ---- sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_echo_level <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (echo_samples.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
            req_valid      <= 1'b1;
            req_echo_level <= echo_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---- receiver, with one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (cycle_count == 400) begin
         rsp_ready  <= 1'b0;
         stall_left <= 60;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
      end
   end

   // ---- predictor and checker
   always @(posedge clock) begin : monitor
      reading_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $error("result item with nothing expected");
               failed = 1'b1;
            end else begin
               want = expected_readings.pop_front();
               check_field("trig_out", 32'(want.trig), 32'(rsp_trig_out));
               check_field("buzzer_out", 32'(want.buzz), 32'(rsp_buzzer_out));
               check_field("segment_bits", 32'(want.seg), 32'(rsp_segment_bits));
               check_field("digit_select", 32'(want.digit), 32'(rsp_digit_select));
               check_field("distance_mm", 32'(want.distance), 32'(rsp_distance_mm));
               check_field("new_measure", 32'(want.pulse), 32'(rsp_new_measure));
               check_field("alert_zone", 32'(want.zone), 32'(rsp_alert_zone));
            end
         end
         if (req_valid && req_ready) begin
            advance_ranger(dut_view, cfg_now, req_echo_level, want);
            expected_readings.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL ultrasonic_ranging_alarm_unit");
         $finish;
      end
   end

endmodule

// ===== files.f =====
+incdir+design
design/ura_pkg.sv
design/ura_display.sv
design/ura_ranging.sv
design/ultrasonic_ranging_alarm_unit.sv
dv/tb.sv
